// ----- rtl/u2a_pkg.sv -----
package u2a_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [6:0] out_char;
		logic       out_last;
	} out_item_t;

	// One classified input byte: up to two characters, then maybe a terminator.
	typedef struct packed {
		logic [6:0] c1;
		logic [6:0] c2;
		logic [1:0] n_chars;
		logic       term;
	} job_t;

	localparam logic [15:0] CAPACITY_RESET = 16'd32;

endpackage

// ----- rtl/utf8_umlaut_to_ascii.sv -----
// Channel   Handshake                     Payload
// input     push / full                   in_item  (in_byte, in_last)
// result    empty / pop                   out_item (out_char, out_last)
// config    cfg_valid / cfg_ready         cfg_data (out_capacity)
//
// The front takes one byte per cycle while the job queue has room and classifies it.
// The back emits one result per cycle from the head job while the result side pops, so a byte
// yields zero to three results; the output register sets the sustained rate.
// Reset sets out_capacity to 32 and clears the string state; the job queue starts empty.
// full rises when the job queue is full; a held result blocks new input only once the job queue fills.
module utf8_umlaut_to_ascii #(
	parameter int JOBQ_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  u2a_pkg::in_item_t  in_item,
	output logic               empty,
	input  logic               pop,
	output u2a_pkg::out_item_t out_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data
);
	import u2a_pkg::*;

	logic job_wr, job_rd, job_full, job_empty;
	job_t job_in, job_head;

	assign cfg_ready = 1'b1;
	assign full      = job_full;

	u2a_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_item   (in_item),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.job_full  (job_full),
		.job_wr    (job_wr),
		.job       (job_in)
	);

	u2a_jobq #(.DEPTH(JOBQ_DEPTH)) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_wr),
		.wdata  (job_in),
		.full   (job_full),
		.rd     (job_rd),
		.rdata  (job_head),
		.empty  (job_empty)
	);

	u2a_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job       (job_head),
		.job_rd    (job_rd),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item)
	);

endmodule

// ----- rtl/u2a_front.sv -----
module u2a_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  u2a_pkg::in_item_t in_item,
	input  logic              cfg_valid,
	input  logic [15:0]       cfg_data,
	input  logic              job_full,
	output logic              job_wr,
	output u2a_pkg::job_t     job
);
	import u2a_pkg::*;

	localparam logic [7:0] LEAD_BYTE  = 8'hC3;
	localparam logic [7:0] SEC_SZ     = 8'h9F;
	localparam logic [7:0] SEC_AE     = 8'hA4;
	localparam logic [7:0] SEC_OE     = 8'hB6;
	localparam logic [7:0] SEC_UE     = 8'hBC;
	localparam logic [7:0] SEC_AE_CAP = 8'h84;
	localparam logic [7:0] SEC_OE_CAP = 8'h96;
	localparam logic [7:0] SEC_UE_CAP = 8'h9C;
	localparam logic [7:0] FIRST_PASS = 8'h20;
	localparam logic [7:0] LAST_PASS  = 8'h7D;
	localparam logic [6:0] CH_QMARK   = 7'h3F;
	localparam logic [6:0] CH_E       = 7'h65;
	localparam logic [6:0] CH_S       = 7'h73;
	localparam logic [6:0] CH_A_LO    = 7'h61;
	localparam logic [6:0] CH_O_LO    = 7'h6F;
	localparam logic [6:0] CH_U_LO    = 7'h75;
	localparam logic [6:0] CH_A_UP    = 7'h41;
	localparam logic [6:0] CH_O_UP    = 7'h4F;
	localparam logic [6:0] CH_U_UP    = 7'h55;

	function automatic logic [15:0] reload(input logic [15:0] cap);
		reload = (cap == 16'd0) ? 16'd0 : cap - 16'd1;
	endfunction

	logic        lead_q, lead_d;
	logic        stop_q, stop_d;
	logic [15:0] room_q, room_d;
	logic [15:0] cap_q;
	logic        accept;
	logic [1:0]  want;
	logic [1:0]  n_chars;
	logic        is_lead;
	logic [6:0]  c1, c2;
	logic [15:0] room_after;
	logic        term;

	assign accept = push && !job_full;

	always_comb begin
		want    = 2'd1;
		c1      = CH_QMARK;
		c2      = CH_E;
		is_lead = 1'b0;
		if (lead_q) begin
			want = 2'd2;
			unique case (in_item.in_byte)
				SEC_SZ: begin
					c1 = CH_S;
					c2 = CH_S;
				end
				SEC_AE:     c1 = CH_A_LO;
				SEC_OE:     c1 = CH_O_LO;
				SEC_UE:     c1 = CH_U_LO;
				SEC_AE_CAP: c1 = CH_A_UP;
				SEC_OE_CAP: c1 = CH_O_UP;
				SEC_UE_CAP: c1 = CH_U_UP;
				default:    want = 2'd1;
			endcase
		end else if (in_item.in_byte >= FIRST_PASS && in_item.in_byte <= LAST_PASS) begin
			c1 = in_item.in_byte[6:0];
		end else if (in_item.in_byte == LEAD_BYTE && !in_item.in_last) begin
			is_lead = 1'b1;
			want    = 2'd0;
		end
		// An expansion with a single slot left keeps only its first letter.
		n_chars    = (want == 2'd2 && room_q == 16'd1) ? 2'd1 : want;
		room_after = room_q - {14'd0, n_chars};
		term       = (room_after == 16'd0) || in_item.in_last;
	end

	always_comb begin
		lead_d = lead_q;
		stop_d = stop_q;
		room_d = room_q;
		job_wr = 1'b0;
		job    = '{c1: c1, c2: c2, n_chars: 2'd0, term: 1'b1};
		if (accept) begin
			if (stop_q) begin
				// Dropped byte; nothing comes out.
			end else if (room_q == 16'd0) begin
				job_wr = 1'b1;
				stop_d = 1'b1;
			end else begin
				lead_d      = is_lead;
				room_d      = room_after;
				job.n_chars = n_chars;
				job.term    = term;
				job_wr      = (n_chars != 2'd0) || term;
				stop_d      = (room_after == 16'd0);
			end
			if (in_item.in_last) begin
				lead_d = 1'b0;
				stop_d = 1'b0;
				room_d = reload(cap_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAPACITY_RESET;
			room_q <= reload(CAPACITY_RESET);
			lead_q <= 1'b0;
			stop_q <= 1'b0;
		end else if (cfg_valid) begin
			cap_q  <= cfg_data;
			room_q <= reload(cfg_data);
			lead_q <= 1'b0;
			stop_q <= 1'b0;
		end else begin
			room_q <= room_d;
			lead_q <= lead_d;
			stop_q <= stop_d;
		end
	end

	// A held lead byte never leaves the room at zero, so it cannot coexist with a stop.
	a_stop_no_lead: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q |-> !lead_q) else $error("lead byte pending while stopped");

	a_stop_room_zero: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q |-> room_q == 16'd0) else $error("stopped with room left");

endmodule

// ----- rtl/u2a_jobq.sv -----
module u2a_jobq #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  u2a_pkg::job_t wdata,
	output logic          full,
	input  logic          rd,
	output u2a_pkg::job_t rdata,
	output logic          empty
);
	import u2a_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
		nxt = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= nxt(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= nxt(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("job queue count overflow");

endmodule

// ----- rtl/u2a_back.sv -----
module u2a_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_empty,
	input  u2a_pkg::job_t      job,
	output logic               job_rd,
	output logic               empty,
	input  logic               pop,
	output u2a_pkg::out_item_t out_item
);
	import u2a_pkg::*;

	logic       out_valid_q;
	out_item_t  out_item_q;
	logic [1:0] idx_q;
	logic [1:0] total;
	logic       load;
	logic       end_of_job;
	out_item_t  next_item;

	assign total      = job.n_chars + {1'b0, job.term};
	assign end_of_job = (idx_q == total - 2'd1);
	assign load       = !job_empty && (!out_valid_q || pop);
	assign job_rd     = load && end_of_job;

	always_comb begin
		if (idx_q < job.n_chars) begin
			next_item = '{out_char: (idx_q == 2'd0) ? job.c1 : job.c2, out_last: 1'b0};
		end else begin
			next_item = '{out_char: 7'd0, out_last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= end_of_job ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_item_q <= next_item;
		end
	end

	assign empty    = !out_valid_q;
	assign out_item = out_item_q;

	// The position within a job stays inside that job's item count.
	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		!job_empty |-> idx_q < total) else $error("item index past end of job");

endmodule

// ----- bench/utf8_umlaut_to_ascii_test.sv -----
`timescale 1ns / 1ps

module utf8_umlaut_to_ascii_test;
	import u2a_pkg::*;

	localparam logic [7:0] LEAD_BYTE   = 8'hC3;
	localparam logic [7:0] SZ_CODE     = 8'h9F;
	localparam logic [7:0] AE_LC_CODE  = 8'hA4;
	localparam logic [7:0] OE_LC_CODE  = 8'hB6;
	localparam logic [7:0] UE_LC_CODE  = 8'hBC;
	localparam logic [7:0] AE_UC_CODE  = 8'h84;
	localparam logic [7:0] OE_UC_CODE  = 8'h96;
	localparam logic [7:0] UE_UC_CODE  = 8'h9C;
	localparam logic [7:0] PLAIN_FIRST = 8'h20;
	localparam logic [7:0] PLAIN_LAST  = 8'h7D;

	localparam logic [6:0] CH_TERM     = 7'h00;
	localparam logic [6:0] CH_QUESTION = 7'h3F;
	localparam logic [6:0] CH_LC_S     = 7'h73;
	localparam logic [6:0] CH_LC_A     = 7'h61;
	localparam logic [6:0] CH_LC_O     = 7'h6F;
	localparam logic [6:0] CH_LC_U     = 7'h75;
	localparam logic [6:0] CH_UC_A     = 7'h41;
	localparam logic [6:0] CH_UC_O     = 7'h4F;
	localparam logic [6:0] CH_UC_U     = 7'h55;
	localparam logic [6:0] CH_LC_E     = 7'h65;

	localparam int SETTLE_CYCLES = 20;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int STALL_CYCLES  = 300;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	in_item_t    in_item;
	logic        empty;
	logic        pop;
	out_item_t   out_item;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	// Predicted converter state.
	logic [15:0] capacity_reg;
	logic [15:0] room_left;
	logic        lead_held;
	logic        dropping;

	out_item_t   expected_chars[$];
	int          error_count = 0;
	int          items_sent = 0;
	bit          tx_idle_en;
	bit          rx_idle_en;
	int          hold_request = 0;

	utf8_umlaut_to_ascii DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_item   (in_item),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	task automatic restart_string();
		lead_held = 1'b0;
		dropping = 1'b0;
		room_left = (capacity_reg == 16'd0) ? 16'd0 : capacity_reg - 16'd1;
	endtask

	task automatic expect_char(input logic [6:0] c, input logic term);
		out_item_t exp_item;
		exp_item.out_char = c;
		exp_item.out_last = term;
		expected_chars.push_back(exp_item);
	endtask

	task automatic convert_byte(input logic [7:0] b, input logic last);
		logic [6:0] c1;
		logic [6:0] c2;
		int want;
		int i;
		c1 = CH_QUESTION;
		c2 = CH_LC_E;
		want = 0;
		if (dropping) begin
			if (last)
				restart_string();
			return;
		end
		if (room_left == 16'd0) begin
			expect_char(CH_TERM, 1'b1);
			if (last)
				restart_string();
			else
				dropping = 1'b1;
			return;
		end
		if (lead_held) begin
			lead_held = 1'b0;
			want = 2;
			case (b)
				SZ_CODE: begin
					c1 = CH_LC_S;
					c2 = CH_LC_S;
				end
				AE_LC_CODE: c1 = CH_LC_A;
				OE_LC_CODE: c1 = CH_LC_O;
				UE_LC_CODE: c1 = CH_LC_U;
				AE_UC_CODE: c1 = CH_UC_A;
				OE_UC_CODE: c1 = CH_UC_O;
				UE_UC_CODE: c1 = CH_UC_U;
				default: want = 1;
			endcase
		end else if (b >= PLAIN_FIRST && b <= PLAIN_LAST) begin
			c1 = b[6:0];
			want = 1;
		end else if (b == LEAD_BYTE && !last) begin
			lead_held = 1'b1;
		end else begin
			want = 1;
		end
		// An expansion that meets the last free slot is cut to its first letter.
		for (i = 0; i < want && room_left != 16'd0; i++) begin
			expect_char((i == 0) ? c1 : c2, 1'b0);
			room_left = room_left - 16'd1;
		end
		if (room_left == 16'd0) begin
			expect_char(CH_TERM, 1'b1);
			if (last)
				restart_string();
			else
				dropping = 1'b1;
		end else if (last) begin
			expect_char(CH_TERM, 1'b1);
			restart_string();
		end
	endtask

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_item(input logic [7:0] b, input logic last);
		int gap;
		gap = tx_idle_en ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		in_item <= {b, last};
		do @(posedge clk); while (full);
		convert_byte(b, last);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drain();
		push <= 1'b0;
		while (expected_chars.size() != 0)
			@(negedge clk);
		// Dropped bytes and a held lead byte leave no result behind them.
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] value);
		wait_drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		capacity_reg = value;
		restart_string();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] umlaut_code(input int k);
		case (k)
			0: return SZ_CODE;
			1: return AE_LC_CODE;
			2: return OE_LC_CODE;
			3: return UE_LC_CODE;
			4: return AE_UC_CODE;
			5: return OE_UC_CODE;
			default: return UE_UC_CODE;
		endcase
	endfunction

	// Mostly well-formed text with umlaut pairs; some noise bytes and a few
	// strings that run on without a last flag.
	task automatic send_random_text();
		int units;
		int u;
		int kind;
		bit ends;
		logic [7:0] text[$];
		units = $urandom_range(1, 10);
		ends = ($urandom_range(0, 7) != 0);
		for (u = 0; u < units; u++) begin
			kind = $urandom_range(0, 11);
			if (kind <= 4) begin
				text.push_back(8'($urandom_range(PLAIN_FIRST, PLAIN_LAST)));
			end else if (kind <= 7) begin
				text.push_back(LEAD_BYTE);
				text.push_back(umlaut_code($urandom_range(0, 6)));
			end else if (kind <= 9) begin
				text.push_back(8'($urandom_range(0, 255)));
			end else if (kind == 10) begin
				text.push_back(LEAD_BYTE);
				text.push_back(8'($urandom_range(0, 255)));
			end else begin
				text.push_back(LEAD_BYTE);
			end
		end
		foreach (text[i])
			send_item(text[i], ends && (i == text.size() - 1));
	endtask

	task automatic test_plain_and_umlauts();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		// Reset capacity of 32 holds all of these strings.
		send_item(8'h41, 1'b0);
		send_item(PLAIN_FIRST, 1'b0);
		send_item(PLAIN_LAST, 1'b0);
		send_item(8'h7E, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b1);
		for (int k = 0; k < 7; k++) begin
			send_item(LEAD_BYTE, 1'b0);
			send_item(umlaut_code(k), k == 6);
		end
		// Unknown second byte, a lead after a lead, and a lead as the last byte.
		send_item(LEAD_BYTE, 1'b0);
		send_item(8'h41, 1'b0);
		send_item(LEAD_BYTE, 1'b0);
		send_item(LEAD_BYTE, 1'b0);
		send_item(LEAD_BYTE, 1'b1);
	endtask

	task automatic test_capacity_limits();
		// No room at all: the first byte only ends the string.
		write_capacity(16'd1);
		send_item(8'h61, 1'b0);
		send_item(8'h62, 1'b1);
		send_item(8'h78, 1'b1);
		// One slot left for an expansion.
		write_capacity(16'd2);
		send_item(LEAD_BYTE, 1'b0);
		send_item(AE_LC_CODE, 1'b0);
		send_item(8'h7A, 1'b1);
		write_capacity(16'd3);
		send_item(8'h61, 1'b0);
		send_item(8'h62, 1'b1);
		send_item(8'h71, 1'b0);
		send_item(LEAD_BYTE, 1'b0);
		send_item(SZ_CODE, 1'b0);
		send_item(8'h21, 1'b1);
		write_capacity(16'd0);
		send_item(8'h61, 1'b0);
		send_item(LEAD_BYTE, 1'b1);
		write_capacity(16'hFFFF);
		send_item(8'h4D, 1'b0);
		send_item(LEAD_BYTE, 1'b0);
		send_item(UE_UC_CODE, 1'b1);
	endtask

	task automatic test_input_stall();
		write_capacity(16'hFFFF);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		// The result side stops while bytes keep coming, so full must rise.
		hold_request = STALL_CYCLES;
		for (int i = 0; i < 24; i++)
			send_item(8'($urandom_range(PLAIN_FIRST, PLAIN_LAST)), i == 23);
	endtask

	task automatic test_drained_restart();
		write_capacity(16'd8);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		send_item(8'h47, 1'b0);
		send_item(8'h72, 1'b0);
		wait_drain();
		// The lead byte must stay held across a quiet period.
		send_item(LEAD_BYTE, 1'b0);
		wait_drain();
		send_item(UE_LC_CODE, 1'b0);
		send_item(LEAD_BYTE, 1'b0);
		send_item(SZ_CODE, 1'b0);
		wait_drain();
		send_item(8'h65, 1'b0);
		send_item(8'h6E, 1'b1);
	endtask

	task automatic test_random_strings();
		int phase;
		int start_count;
		logic [15:0] cap;
		for (phase = 0; phase < 9; phase++) begin
			case (phase)
				0: cap = 16'd1;
				1: cap = 16'd2;
				2: cap = 16'd3;
				3: cap = 16'hFFFF;
				4: cap = CAPACITY_RESET;
				default: cap = 16'($urandom_range(2, 12));
			endcase
			write_capacity(cap);
			start_count = items_sent;
			while (items_sent - start_count < 13) begin
				tx_idle_en = ($urandom_range(0, 3) != 0);
				rx_idle_en = ($urandom_range(0, 3) != 0);
				send_random_text();
			end
		end
	endtask

	// Result side: pop after a random wait, or after a long hold when one is asked.
	initial begin
		int gap;
		pop = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = rx_idle_en ? $urandom_range(0, 11) : 0;
			if (hold_request > 0) begin
				gap = hold_request;
				hold_request = 0;
			end
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		out_item_t exp_item;
		if (arst_n && pop && !empty) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected result, got char %h last %b",
					$time, out_item.out_char, out_item.out_last);
				error_count++;
			end else begin
				exp_item = expected_chars.pop_front();
				if (out_item.out_char !== exp_item.out_char ||
						out_item.out_last !== exp_item.out_last) begin
					$display("%0t: mismatch, expected char %h last %b, got char %h last %b",
						$time, exp_item.out_char, exp_item.out_last,
						out_item.out_char, out_item.out_last);
					error_count++;
				end
			end
		end
	end

	initial begin
		int w;
		arst_n = 1'b0;
		push = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_data = CAPACITY_RESET;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		capacity_reg = CAPACITY_RESET;
		restart_string();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_plain_and_umlauts();
		test_capacity_limits();
		test_input_stall();
		test_drained_restart();
		test_random_strings();

		push <= 1'b0;
		for (w = 0; w < DRAIN_LIMIT && expected_chars.size() != 0; w++)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_chars.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				expected_chars.size());
			error_count++;
		end
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("%0t: timeout", $time);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- utf8_umlaut_to_ascii.f -----
rtl/u2a_pkg.sv
rtl/u2a_front.sv
rtl/u2a_jobq.sv
rtl/u2a_back.sv
rtl/utf8_umlaut_to_ascii.sv
bench/utf8_umlaut_to_ascii_test.sv
